// ----- rtl/core/fpr_pkg.sv -----
// Shared types and constants for the fire palette recolor pipeline.
package fpr_pkg;

  // Pixel as carried on tdata: blue in the lowest byte, red in the highest.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  // Luminance in 8.8 fixed point
  localparam int LUM_W = 16;
  localparam int SEG_W = 14;

  localparam logic [7:0] LUMA_WB = 8'd29;
  localparam logic [7:0] LUMA_WG = 8'd150;
  localparam logic [7:0] LUMA_WR = 8'd77;

  // Palette segment, taken from the two top bits of the luminance
  typedef enum logic [1:0] {
    SEG_DARK   = 2'd0,
    SEG_RED    = 2'd1,
    SEG_ORANGE = 2'd2,
    SEG_YELLOW = 2'd3
  } seg_t;

  // Palette slopes and offsets
  localparam logic [7:0] PAL_DARK_R   = 8'd150;
  localparam logic [7:0] PAL_RED_G    = 8'd100;
  localparam logic [7:0] PAL_RED_R    = 8'd105;
  localparam logic [7:0] PAL_ORANGE_G = 8'd155;
  localparam logic [7:0] PAL_FULL     = 8'd255;

  // floor(x / 63) as (x * ceil(2^20 / 63)) >> 20, exact for x below 2^14
  localparam int          RECIP_SHIFT = 20;
  localparam logic [14:0] RECIP_63    = 15'd16645;

  // Blend factor in Q1.8
  localparam int             FACTOR_W    = 9;
  localparam logic [8:0]     FACTOR_FULL = 9'd256;

  // Configuration register map
  localparam int          PADDR_W      = 3;
  localparam logic [0:0]  REG_FIRE_IDX = 1'b0;

endpackage

// ----- rtl/core/fpr_cfg.sv -----
// Configuration register block: fire blend factor behind an APB-style port.
module fpr_cfg import fpr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output logic [FACTOR_W-1:0] fire_eff
);

  logic [FACTOR_W-1:0] fire_factor;
  logic                wr_fire;
  logic [FACTOR_W-1:0] wr_value;

  assign pready   = 1'b1;
  assign wr_fire  = psel && penable && pwrite && (paddr[2] == REG_FIRE_IDX);
  assign wr_value = pwdata[FACTOR_W-1:0];

  // Hold the raw register and its saturated copy used by the datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      fire_factor <= '0;
      fire_eff    <= '0;
    end else if (wr_fire) begin
      fire_factor <= wr_value;
      fire_eff    <= (wr_value > FACTOR_FULL) ? FACTOR_FULL : wr_value;
    end
  end

  // Read back the register value; other addresses read zero
  always_comb begin
    if (paddr[2] == REG_FIRE_IDX) begin
      prdata = {{(32-FACTOR_W){1'b0}}, fire_factor};
    end else begin
      prdata = '0;
    end
  end

endmodule

// ----- rtl/core/fpr_luma.sv -----
// First pipeline stage: weighted luminance of the input pixel in 8.8.
module fpr_luma import fpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pixel_t           in_pix,
  output logic             out_valid,
  input  logic             out_ready,
  output pixel_t           out_pix,
  output logic [LUM_W-1:0] out_lum
);

  logic [LUM_W-1:0] term_b;
  logic [LUM_W-1:0] term_g;
  logic [LUM_W-1:0] term_r;
  logic [LUM_W-1:0] lum_next;

  assign in_ready = !out_valid || out_ready;

  // Weights sum to 256, so the total stays within 16 bits
  assign term_b   = LUM_W'(in_pix.blue)  * LUM_W'(LUMA_WB);
  assign term_g   = LUM_W'(in_pix.green) * LUM_W'(LUMA_WG);
  assign term_r   = LUM_W'(in_pix.red)   * LUM_W'(LUMA_WR);
  assign lum_next = term_b + term_g + term_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Advance payload on every open slot
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_pix <= in_pix;
      out_lum <= lum_next;
    end
  end

endmodule

// ----- rtl/core/fpr_palette.sv -----
// Second and third pipeline stages: piecewise-linear fire palette lookup.
module fpr_palette import fpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pixel_t           in_pix,
  input  logic [LUM_W-1:0] in_lum,
  output logic             out_valid,
  input  logic             out_ready,
  output pixel_t           out_pix,
  output pixel_t           out_pal
);

  seg_t             seg;
  logic [SEG_W-1:0] d;
  logic [SEG_W+7:0] prod_dark_r;
  logic [SEG_W+7:0] prod_red_g;
  logic [SEG_W+7:0] prod_red_r;
  logic [SEG_W+7:0] prod_orange_g;
  logic [SEG_W+7:0] prod_full;
  logic [7:0]       pal_r_next;
  logic [7:0]       pal_g_next;

  // Stage A registers
  logic             a_valid;
  logic             a_ready;
  pixel_t           a_pix;
  logic [7:0]       a_red;
  logic [7:0]       a_green;
  logic             a_yellow;
  logic [SEG_W-1:0] a_scaled;

  // Stage B logic
  logic             b_ready;
  logic [SEG_W+RECIP_SHIFT-6:0] recip_prod;
  logic [SEG_W+RECIP_SHIFT-6-RECIP_SHIFT:0] blue_q;
  logic [7:0]       blue_next;

  assign seg = seg_t'(in_lum[LUM_W-1:SEG_W]);
  assign d   = in_lum[SEG_W-1:0];

  // Constant-coefficient products of the offset inside the segment
  assign prod_dark_r   = (SEG_W+8)'(d) * (SEG_W+8)'(PAL_DARK_R);
  assign prod_red_g    = (SEG_W+8)'(d) * (SEG_W+8)'(PAL_RED_G);
  assign prod_red_r    = (SEG_W+8)'(d) * (SEG_W+8)'(PAL_RED_R);
  assign prod_orange_g = (SEG_W+8)'(d) * (SEG_W+8)'(PAL_ORANGE_G);
  assign prod_full     = (SEG_W+8)'(d) * (SEG_W+8)'(PAL_FULL);

  // Select red and green per segment
  always_comb begin
    case (seg)
      SEG_DARK: begin
        pal_r_next = prod_dark_r[SEG_W+7:SEG_W];
        pal_g_next = 8'd0;
      end
      SEG_RED: begin
        pal_r_next = PAL_DARK_R + prod_red_r[SEG_W+7:SEG_W];
        pal_g_next = prod_red_g[SEG_W+7:SEG_W];
      end
      SEG_ORANGE: begin
        pal_r_next = PAL_FULL;
        pal_g_next = PAL_RED_G + prod_orange_g[SEG_W+7:SEG_W];
      end
      default: begin
        pal_r_next = PAL_FULL;
        pal_g_next = PAL_FULL;
      end
    endcase
  end

  assign b_ready  = !out_valid || out_ready;
  assign a_ready  = !a_valid || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid <= in_valid;
      end
      if (b_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  // Stage A: hold red, green and 255*d/256 for the yellow segment
  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_pix    <= in_pix;
      a_red    <= pal_r_next;
      a_green  <= pal_g_next;
      a_yellow <= (seg == SEG_YELLOW);
      a_scaled <= prod_full[SEG_W+7:8];
    end
  end

  // Stage B: blue = floor(scaled / 63) by reciprocal multiply, clamped to 255, zero outside the yellow segment
  assign recip_prod = (SEG_W+RECIP_SHIFT-5)'(a_scaled) * (SEG_W+RECIP_SHIFT-5)'(RECIP_63);
  assign blue_q     = recip_prod[SEG_W+RECIP_SHIFT-6:RECIP_SHIFT];

  always_comb begin
    if (!a_yellow) begin
      blue_next = 8'd0;
    end else if (blue_q > (SEG_W-5)'(PAL_FULL)) begin
      blue_next = PAL_FULL;
    end else begin
      blue_next = blue_q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      out_pix       <= a_pix;
      out_pal.red   <= a_red;
      out_pal.green <= a_green;
      out_pal.blue  <= blue_next;
    end
  end

endmodule

// ----- rtl/core/fpr_blend.sv -----
// Last pipeline stage: blend palette color with the pixel and register output.
module fpr_blend import fpr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic [FACTOR_W-1:0] fire_eff,
  input  logic                in_valid,
  output logic                in_ready,
  input  pixel_t              in_pix,
  input  pixel_t              in_pal,
  output logic                out_valid,
  input  logic                out_ready,
  output pixel_t              out_pix
);

  logic [FACTOR_W-1:0] keep;
  pixel_t              mix;

  function automatic logic [7:0] blend_ch(input logic [7:0] pix, input logic [7:0] pal,
                                          input logic [FACTOR_W-1:0] f,
                                          input logic [FACTOR_W-1:0] k);
    logic [16:0] sum;
    sum = 17'(pix) * 17'(k) + 17'(pal) * 17'(f);
    return sum[15:8];
  endfunction

  assign keep     = FACTOR_FULL - fire_eff;
  assign in_ready = !out_valid || out_ready;

  assign mix.blue  = blend_ch(in_pix.blue,  in_pal.blue,  fire_eff, keep);
  assign mix.green = blend_ch(in_pix.green, in_pal.green, fire_eff, keep);
  assign mix.red   = blend_ch(in_pix.red,   in_pal.red,   fire_eff, keep);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // Hold the result while the receiver stalls
  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_pix <= mix;
    end
  end

endmodule

// ----- rtl/core/fire_palette_recolor.sv -----
// Top level of the fire palette recolor pipeline.
//
// Input pixels arrive on the s_axis group: s_tdata carries blue, green and
// red, one byte each from the lowest bit up. Recolored pixels leave on the
// m_axis group in the same layout. A transaction completes on an edge where
// tvalid and tready are both high.
// The fire_factor register (Q1.8, 0 keeps the pixel, 256 gives full fire
// color, larger values act as 256) sits at byte address 0 of the APB-style
// port; write it only while the pipeline holds no pixel.
// Luminance, palette segment products, the divide-by-63 reciprocal
// multiply and the blend multiply each take one register stage.
// Throughput is one pixel per clock while m_tready stays high; each stage
// advances whenever its downstream slot is empty or moving.
// When the receiver stalls, every stage holds its pixel and s_tready drops
// once the pipeline is full; nothing is lost or repeated.
// Reset clears all valid bits and sets fire_factor to 0.
module fire_palette_recolor import fpr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // Pixel input
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [23:0]        s_tdata,   // blue_in[7:0], green_in[15:8], red_in[23:16]
  // Pixel output
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [23:0]        m_tdata,   // blue_out[7:0], green_out[15:8], red_out[23:16]
  // Configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [FACTOR_W-1:0] fire_eff;

  logic             luma_valid;
  logic             luma_ready;
  pixel_t           luma_pix;
  logic [LUM_W-1:0] luma_lum;

  logic             pal_valid;
  logic             pal_ready;
  pixel_t           pal_pix;
  pixel_t           pal_color;

  pixel_t           res_pix;

  assign m_tdata = res_pix;

  fpr_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .fire_eff (fire_eff)
  );

  fpr_luma u_luma (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pix    (pixel_t'(s_tdata)),
    .out_valid (luma_valid),
    .out_ready (luma_ready),
    .out_pix   (luma_pix),
    .out_lum   (luma_lum)
  );

  fpr_palette u_palette (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (luma_valid),
    .in_ready  (luma_ready),
    .in_pix    (luma_pix),
    .in_lum    (luma_lum),
    .out_valid (pal_valid),
    .out_ready (pal_ready),
    .out_pix   (pal_pix),
    .out_pal   (pal_color)
  );

  fpr_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .fire_eff  (fire_eff),
    .in_valid  (pal_valid),
    .in_ready  (pal_ready),
    .in_pix    (pal_pix),
    .in_pal    (pal_color),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pix   (res_pix)
  );

endmodule
